### rtl/spq_pkg.sv
// Shared types and constants for the strict-priority three-class queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CLASS_COUNT = 3;

  localparam int ID_W     = 16;
  localparam int CLS_W    = 2;
  localparam int STATUS_W = 3;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int CIDX_W = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int ENTRY_DEPTH = CLASS_COUNT * QUEUE_DEPTH;
  localparam int ADDR_W = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_SERVE   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ENQUEUED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SERVED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd4;

  typedef struct packed {
    logic             action;
    logic [ID_W-1:0]  entry_id;
    logic [CLS_W-1:0] entry_class;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     served_id;
    logic [CLS_W-1:0]    served_class;
  } out_item_t;

  // Memory command from the queue control to the entry store.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   wdata;
  } mem_cmd_t;

  // Outcome of a request, carried alongside the store read.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CLS_W-1:0]    cls;
  } resp_info_t;

endpackage

### rtl/spq_queue_ctrl.sv
// Per-class head pointers and counts; decides each request and issues the store access.
`timescale 1ns / 1ps
module spq_queue_ctrl
  import spq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       req_valid,
  input  in_item_t   req,
  output mem_cmd_t   cmd,
  output resp_info_t info
);

  logic [PTR_W-1:0] head_r   [CLASS_COUNT];
  logic [PTR_W-1:0] head_nxt [CLASS_COUNT];
  logic [CNT_W-1:0] count_r  [CLASS_COUNT];
  logic [CNT_W-1:0] count_nxt[CLASS_COUNT];

  logic              cls_ok;
  logic [CIDX_W-1:0] enq_idx;
  logic [SUM_W-1:0]  tail_sum;
  logic [PTR_W-1:0]  tail_slot;
  logic              found;
  logic [CIDX_W-1:0] pick;
  logic [PTR_W-1:0]  pick_head;

  always_comb begin
    cls_ok  = int'(req.entry_class) < CLASS_COUNT;
    enq_idx = CIDX_W'(req.entry_class);

    // Tail slot: head plus count, wrapped once.
    tail_sum = SUM_W'(head_r[enq_idx]) + SUM_W'(count_r[enq_idx]);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail_slot = PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
    end else begin
      tail_slot = PTR_W'(tail_sum);
    end

    // Lowest-numbered non-empty class wins.
    found = 1'b0;
    pick  = '0;
    for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
      if (count_r[c] != '0) begin
        found = 1'b1;
        pick  = CIDX_W'(c);
      end
    end
    pick_head = head_r[pick];

    for (int c = 0; c < CLASS_COUNT; c++) begin
      head_nxt[c]  = head_r[c];
      count_nxt[c] = count_r[c];
    end

    cmd.we    = 1'b0;
    cmd.re    = 1'b0;
    cmd.addr  = '0;
    cmd.wdata = req.entry_id;
    info.cls  = '0;

    if (req.action == ACT_ENQUEUE) begin
      if (!cls_ok) begin
        info.status = ST_INVALID;
      end else if (count_r[enq_idx] >= CNT_W'(QUEUE_DEPTH)) begin
        info.status = ST_FULL;
      end else begin
        info.status = ST_ENQUEUED;
        cmd.we      = req_valid;
        cmd.addr    = ADDR_W'(int'(enq_idx) * QUEUE_DEPTH + int'(tail_slot));
        count_nxt[enq_idx] = count_r[enq_idx] + CNT_W'(1);
      end
    end else begin
      if (!found) begin
        info.status = ST_EMPTY;
      end else begin
        info.status = ST_SERVED;
        info.cls    = CLS_W'(pick);
        cmd.re      = req_valid;
        cmd.addr    = ADDR_W'(int'(pick) * QUEUE_DEPTH + int'(pick_head));
        if (pick_head == PTR_W'(QUEUE_DEPTH - 1)) begin
          head_nxt[pick] = '0;
        end else begin
          head_nxt[pick] = pick_head + PTR_W'(1);
        end
        count_nxt[pick] = count_r[pick] - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
        head_r[c]  <= '0;
        count_r[c] <= '0;
      end
    end else if (req_valid) begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
        head_r[c]  <= head_nxt[c];
        count_r[c] <= count_nxt[c];
      end
    end
  end

endmodule

### rtl/strict_priority_three_class_queue_top.sv
// Top level of the strict-priority three-class queue: entry store and result pipeline.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_valid/in_stall/in_data carries one request: an enqueue
//   of entry_id into class entry_class, or a serve of the oldest entry of the
//   highest-priority non-empty class. Every request returns exactly one result
//   on out_valid/out_stall/out_data with a status, and the served identifier
//   and class when the status is served (zero otherwise).
//   Path: an accepted request's result passes through the entry store read
//   register and then the output register before it shows on out_data.
//   Throughput: one request per cycle while in_stall is low; the single-port
//   entry store takes one access per request, and pointers and counts update
//   in the same cycle, so back-to-back requests to the same class need no interlock.
//   Reset (rst_n low, synchronous) empties all queues and drops any result in
//   flight; store contents are not cleared and need not be.
//   When out_stall is high, the result holds in the output register, one more
//   request may wait in the read stage, and in_stall then rises until the
//   output is taken.
module strict_priority_three_class_queue_top
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic       in_acc;
  mem_cmd_t   cmd;
  resp_info_t info;

  logic [ID_W-1:0] mem [ENTRY_DEPTH];
  logic [ID_W-1:0] rd_r;

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  resp_info_t s1_info_r;
  logic       s1_adv;

  logic       out_valid_r;
  logic       out_valid_nxt;
  out_item_t  out_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  spq_queue_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_acc),
    .req       (in_data),
    .cmd       (cmd),
    .info      (info)
  );

  // Entry store; read data holds until the next read.
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.addr] <= cmd.wdata;
    end
    if (cmd.re) begin
      rd_r <= mem[cmd.addr];
    end
  end

  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_info_r <= info;
    end
    if (s1_adv) begin
      out_r.status       <= s1_info_r.status;
      out_r.served_class <= s1_info_r.cls;
      if (s1_info_r.status == ST_SERVED) begin
        out_r.served_id <= rd_r;
      end else begin
        out_r.served_id <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
